[src/tcgcc_pkg.sv]
// Shared types, codes and constants for the timecode generator with cue compare.
`timescale 1ns / 1ps
package tcgcc_pkg;

   // Default number of cue table entries
   localparam int NUM_CUES_DEF = 8;

   // Configuration port
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_RATE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_TC = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_EN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHECK_EN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SERIAL_EN = 3'd4;

   localparam logic [7:0] FRAME_RATE_RST = 8'd25;

   // Item actions
   localparam logic [1:0] ACT_FRAME = 2'd0;
   localparam logic [1:0] ACT_FIELD = 2'd1;
   localparam logic [1:0] ACT_ARM = 2'd2;
   localparam logic [1:0] ACT_RESTART = 2'd3;

   // Serial word markers
   localparam logic [8:0] MARK_FRAMES = 9'h120;
   localparam logic [8:0] MARK_SECONDS = 9'h140;
   localparam logic [8:0] MARK_MINUTES = 9'h180;
   localparam logic [8:0] MARK_HOURS = 9'h1C0;

   typedef struct packed {
      logic [1:0] action;
      logic [2:0] cue_index;
      logic [31:0] cue_target;
      logic cue_untimed;
   } req_payload_type;

   typedef struct packed {
      logic serial_valid;
      logic [8:0] serial_word;
      logic cue_signal;
      logic [7:0] collected_mask;
      logic [31:0] current_timecode;
   } rsp_payload_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic rd_en;
      logic load_walk;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic need_walk;
      logic rd_last;
   } status_type;

endpackage

[src/tcgcc_ctrl.sv]
// Controller state machine: item handshake, cue table walk sequencing and result valid.
`timescale 1ns / 1ps
module tcgcc_ctrl (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input logic rsp_ready,
   input tcgcc_pkg::status_type st,
   output tcgcc_pkg::cmd_type cmd
);
   import tcgcc_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.accept = 1'b1;
               if (st.need_walk) begin
                  state_in = ST_WALK;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_WALK: begin
            cmd.rd_en = 1'b1;
            if (st.rd_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.load_walk = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[src/tcgcc_dp.sv]
// Datapath: timecode counter, field state, configuration, cue table and result register.
`timescale 1ns / 1ps
module tcgcc_dp #(
   parameter int NUM_CUES = tcgcc_pkg::NUM_CUES_DEF
) (
   input logic clock,
   input logic reset,
   input logic csr_write_en,
   input logic [tcgcc_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [tcgcc_pkg::CSR_DATA_W-1:0] csr_wdata,
   input tcgcc_pkg::req_payload_type req_payload,
   output tcgcc_pkg::rsp_payload_type rsp_payload,
   input tcgcc_pkg::cmd_type cmd,
   output tcgcc_pkg::status_type st
);
   import tcgcc_pkg::*;

   localparam int IDX_W = (NUM_CUES > 1) ? $clog2(NUM_CUES) : 1;

   // Configuration
   logic [7:0] frame_rate_ff;
   logic [31:0] start_tc_ff;
   logic count_en_ff, check_en_ff, serial_en_ff;

   // Counter state
   logic [31:0] timecode_ff, timecode_in;
   logic odd_ff, odd_in;
   logic [1:0] fc_ff, fc_in;

   // Cue table
   logic [31:0] cue_time_mem [NUM_CUES];
   logic [NUM_CUES-1:0] waiting_ff, waiting_in;
   logic [NUM_CUES-1:0] untimed_ff, untimed_in;
   logic [NUM_CUES-1:0] done_ff, done_in;

   // Walk pipeline
   logic [IDX_W-1:0] rd_addr_ff;
   logic [IDX_W-1:0] cmp_idx_ff;
   logic cmp_en_ff;
   logic [31:0] rd_data_ff;
   logic sig_ff;
   logic hit;

   logic [6:0] idx_ext;
   logic arm_ok;
   logic [IDX_W-1:0] arm_idx;
   logic counted;
   logic [NUM_CUES+7:0] mask_now_ext, mask_ff_ext;
   rsp_payload_type rsp_ff;

   function automatic logic [31:0] advance_frame(input logic [31:0] tc_i,
                                                 input logic [7:0] rate);
      logic [31:0] tc;
      tc = tc_i + 32'd1;
      if (tc[7:0] == rate) begin
         tc = (tc & 32'hFFFF_FF00) + 32'h0000_0100;
         if (tc[15:8] == 8'd60) begin
            tc = tc + (32'd196 << 8);
            if (tc[23:16] == 8'd60) begin
               tc = tc + (32'd196 << 16);
               if (tc[31:24] == 8'd24) begin
                  tc = tc & 32'h00FF_FFFF;
               end
            end
         end
      end
      return tc;
   endfunction

   function automatic logic [8:0] serial_byte(input logic [1:0] fc, input logic [31:0] tc);
      logic [8:0] w;
      case (fc)
         2'd0: w = {1'b0, tc[7:0]} | MARK_FRAMES;
         2'd1: w = {1'b0, tc[15:8]} | MARK_SECONDS;
         2'd2: w = {1'b0, tc[23:16]} | MARK_MINUTES;
         default: w = {1'b0, tc[31:24]} | MARK_HOURS;
      endcase
      return w;
   endfunction

   assign idx_ext = {4'b0, req_payload.cue_index};
   assign arm_ok = idx_ext < 7'(NUM_CUES);
   assign arm_idx = idx_ext[IDX_W-1:0];
   assign counted = (req_payload.action == ACT_FIELD) && odd_ff && count_en_ff;

   assign st.need_walk = counted && check_en_ff;
   assign st.rd_last = (rd_addr_ff == IDX_W'(NUM_CUES - 1));

   assign hit = cmp_en_ff && waiting_ff[cmp_idx_ff]
                && ((rd_data_ff <= timecode_ff) || untimed_ff[cmp_idx_ff]);

   always_comb begin
      timecode_in = timecode_ff;
      odd_in = odd_ff;
      fc_in = fc_ff;
      waiting_in = waiting_ff;
      untimed_in = untimed_ff;
      done_in = done_ff;
      if (cmd.accept) begin
         case (req_payload.action)
            ACT_FRAME: begin
               timecode_in = advance_frame(timecode_ff, frame_rate_ff);
            end
            ACT_FIELD: begin
               odd_in = !odd_ff;
               if (counted) begin
                  fc_in = fc_ff + 2'd1;
               end
            end
            ACT_ARM: begin
               if (arm_ok) begin
                  waiting_in[arm_idx] = 1'b1;
                  done_in[arm_idx] = 1'b0;
                  untimed_in[arm_idx] = req_payload.cue_untimed;
               end
            end
            ACT_RESTART: begin
               timecode_in = start_tc_ff;
               odd_in = 1'b1;
               fc_in = 2'd0;
            end
            default: begin
               timecode_in = timecode_ff;
            end
         endcase
      end
      if (hit) begin
         waiting_in[cmp_idx_ff] = 1'b0;
         done_in[cmp_idx_ff] = 1'b1;
      end
   end

   assign mask_now_ext = {8'b0, done_in};
   assign mask_ff_ext = {8'b0, done_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_rate_ff <= FRAME_RATE_RST;
         start_tc_ff <= '0;
         count_en_ff <= 1'b0;
         check_en_ff <= 1'b1;
         serial_en_ff <= 1'b0;
         timecode_ff <= '0;
         odd_ff <= 1'b1;
         fc_ff <= '0;
         waiting_ff <= '0;
         untimed_ff <= '0;
         done_ff <= '0;
         cmp_en_ff <= 1'b0;
         sig_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_FRAME_RATE: frame_rate_ff <= csr_wdata[7:0];
               CSR_START_TC: start_tc_ff <= csr_wdata[31:0];
               CSR_COUNT_EN: count_en_ff <= csr_wdata[0];
               CSR_CHECK_EN: check_en_ff <= csr_wdata[0];
               CSR_SERIAL_EN: serial_en_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         timecode_ff <= timecode_in;
         odd_ff <= odd_in;
         fc_ff <= fc_in;
         waiting_ff <= waiting_in;
         untimed_ff <= untimed_in;
         done_ff <= done_in;
         cmp_en_ff <= cmd.rd_en;
         if (cmd.accept) begin
            sig_ff <= 1'b0;
         end else if (hit) begin
            sig_ff <= 1'b1;
         end
      end
   end

   // Cue target store and its registered read port
   always_ff @(posedge clock) begin
      if (cmd.accept && (req_payload.action == ACT_ARM) && arm_ok) begin
         cue_time_mem[arm_idx] <= req_payload.cue_target;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= cue_time_mem[rd_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= rd_addr_ff;
      if (cmd.accept) begin
         rd_addr_ff <= '0;
      end else if (cmd.rd_en) begin
         rd_addr_ff <= rd_addr_ff + 1'b1;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.accept && !st.need_walk) begin
         rsp_ff.serial_valid <= counted && serial_en_ff;
         rsp_ff.serial_word <= (counted && serial_en_ff) ? serial_byte(fc_in, timecode_ff)
                                                         : 9'd0;
         rsp_ff.cue_signal <= 1'b0;
         rsp_ff.collected_mask <= mask_now_ext[7:0];
         rsp_ff.current_timecode <= timecode_in;
      end else if (cmd.load_walk) begin
         rsp_ff.serial_valid <= serial_en_ff;
         rsp_ff.serial_word <= serial_en_ff ? serial_byte(fc_ff, timecode_ff) : 9'd0;
         rsp_ff.cue_signal <= sig_ff;
         rsp_ff.collected_mask <= mask_ff_ext[7:0];
         rsp_ff.current_timecode <= timecode_ff;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

[src/timecode_generator_cue_compare_core.sv]
// Top level of the timecode generator with cue compare: controller, datapath and checks.
`timescale 1ns / 1ps
// Frame pulses, arms, restarts and field ticks that need no cue check give their result in the
// cycle after the item is accepted. A counted field tick with checking enabled walks the
// cue table through its single read port, one entry a cycle, then passes the drain and
// finish states before its result is valid; no new item is taken until that result is shown.
// Items without a check can be taken one per cycle while each result is taken as it appears.
// Reset (synchronous, active high) clears the timecode, field count and cue flags, marks
// the field as odd and returns the configuration registers to their reset values.
module timecode_generator_cue_compare_core #(
   parameter int NUM_CUES = tcgcc_pkg::NUM_CUES_DEF
) (
   input logic clock,
   input logic reset,
   // Configuration write port
   input logic csr_write_en,
   input logic [tcgcc_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [tcgcc_pkg::CSR_DATA_W-1:0] csr_wdata,
   // Input items
   input logic req_valid,
   output logic req_ready,
   input tcgcc_pkg::req_payload_type req_payload,
   // Result items
   output logic rsp_valid,
   input logic rsp_ready,
   output tcgcc_pkg::rsp_payload_type rsp_payload
);
   import tcgcc_pkg::*;

   // The controller owns the handshake and sequences the walk over the cue table; the
   // datapath owns all timecode and cue state and the result register.
   cmd_type cmd;
   status_type st;

   tcgcc_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .st(st),
      .cmd(cmd)
   );

   tcgcc_dp #(
      .NUM_CUES(NUM_CUES)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_payload(req_payload),
      .rsp_payload(rsp_payload),
      .cmd(cmd),
      .st(st)
   );

   // A serial word always carries its top marker bit, and an item without one carries zero.
   a_serial_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.serial_valid ? rsp_payload.serial_word[8]
                                              : (rsp_payload.serial_word == 9'd0)))
      else $error("serial word marker mismatch");

   // When every cue has a bit in the mask, a signalled collection shows in the mask.
   a_signal_mask: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.cue_signal && (NUM_CUES <= 8))
      |-> (rsp_payload.collected_mask != 8'd0))
      else $error("cue signal without any collected cue");

   // An item that starts a cue table walk blocks further items on the next cycle.
   a_walk_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && st.need_walk) |=> !req_ready)
      else $error("item accepted during cue table walk");

   // A walk item never produces its result in the cycle straight after acceptance.
   a_walk_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && st.need_walk && !(rsp_valid && !rsp_ready))
      |=> !rsp_valid)
      else $error("walk result delivered too early");

endmodule
